// ===== rtl/rtc_pkg.sv =====
// Shared constants and codes for the raster tile cache core.
package rtc_pkg;

	localparam int TILE_BITS  = 9;   // 512-pixel tiles
	localparam int SLOT_BITS  = 6;   // 64 slots
	localparam int SLOTS      = 64;
	localparam int TIDX_BITS  = 12;  // 4096 table entries
	localparam int TILES      = 4096;
	localparam int MAP_W      = SLOT_BITS + 1;
	localparam int TILE_SIZE  = 512;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_OVER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BANDS  = 2'd2
	} reg_idx_t;

endpackage

// ===== rtl/raster_tile_cache_lru_core.sv =====
// Top level of the raster tile cache tag and LRU replacement manager.
//
// Each request transaction on s_* carries a read/write kind (tuser) and a 1-based
// band, column and row (tdata). The core checks bounds, splits the pixel into a
// tile and offset, forms the linear tile index, looks it up in a 4096-entry
// tile-to-slot RAM and keeps a doubly linked LRU order over 64 slots in two
// small RAMs. One result transaction on m_* follows each request. Every request
// passes S_MUL, S_TILE and S_LOOK; a rejected one then goes to S_OUT, a hit on
// the oldest or newest slot goes through S_CHK, a miss through S_CHK and S_MISS,
// and a hit that relinks the order list through S_CHK, S_RD, S_RL2 and S_RL3.
// The sequencer handles one request at a time; a miss needs the extra state
// S_MISS because the table RAM takes one write per cycle (old entry cleared,
// then new entry set), and a relink needs S_RD, S_RL2 and S_RL3 because the
// order RAMs take one write per cycle each. The output register lets the next
// request enter while a result waits. After reset a clearing pass sweeps all
// 4096 entries of the tile-to-slot RAM; requests are held off during it,
// configuration writes are taken at any time (cfg_ready is tied high).
module raster_tile_cache_lru_core
	import rtc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] band, [20:5] col, [36:21] row, [39:37] zero
	input  logic [39:0] s_tdata,
	// [0] req_type
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [2] hit, [8:3] slot, [17:9] offset_col, [26:18] offset_row,
	// [27] evict_dirty, [39:28] evict_tile, [51:40] fill_tile,
	// [61:52] fill_width, [71:62] fill_height
	output logic [71:0] m_tdata
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_MUL, S_TILE, S_LOOK, S_CHK, S_MISS,
		S_RD, S_RL2, S_RL3, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] width_q, height_q;
	logic [4:0]  bands_q;

	// request
	logic        wr_q;
	logic [4:0]  band_q;
	logic [15:0] col_q, row_q;
	logic        bad_q;
	logic [6:0]  bx_q, by_q;
	logic [15:0] txty_q;
	logic [14:0] bytx_q;
	logic [20:0] tile_q;

	// lookup
	logic [SLOT_BITS-1:0] oldest_q, s_q, prevq_q, qp_q;
	logic                 hit_q, ed_q;
	logic [TIDX_BITS-1:0] et_q;
	status_t              status_q;
	logic [TIDX_BITS-1:0] clr_q;

	logic [SLOTS-1:0] stile_v_q, dirty_q, onext_w_q, oprev_w_q;
	logic [SLOT_BITS-1:0] on_ra_q, op_ra_q;

	logic [71:0] out_q;
	logic        out_v_q;

	// RAM ports
	logic                 t_we, st_we, on_we, op_we;
	logic [TIDX_BITS-1:0] t_wa, t_ra;
	logic [MAP_W-1:0]     t_wd, t_rd;
	logic [SLOT_BITS-1:0] st_wa, st_ra, on_wa, on_ra, op_wa, op_ra;
	logic [TIDX_BITS-1:0] st_wd, st_rd;
	logic [SLOT_BITS-1:0] on_wd, on_rd, op_wd, op_rd;

	rtc_ram #(.WIDTH(MAP_W), .DEPTH(TILES)) u_map (
		.clk(clk), .we(t_we), .wa(t_wa), .wd(t_wd), .ra(t_ra), .rd(t_rd));
	rtc_ram #(.WIDTH(TIDX_BITS), .DEPTH(SLOTS)) u_stile (
		.clk(clk), .we(st_we), .wa(st_wa), .wd(st_wd), .ra(st_ra), .rd(st_rd));
	rtc_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_next (
		.clk(clk), .we(on_we), .wa(on_wa), .wd(on_wd), .ra(on_ra), .rd(on_rd));
	rtc_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_prev (
		.clk(clk), .we(op_we), .wa(op_wa), .wd(op_wd), .ra(op_ra), .rd(op_rd));

	// unwritten order entries read as their reset links
	logic [SLOT_BITS-1:0] on_val, op_val;
	assign on_val = onext_w_q[on_ra_q] ? on_rd : on_ra_q + 1'b1;
	assign op_val = oprev_w_q[op_ra_q] ? op_rd : op_ra_q - 1'b1;

	logic [SLOT_BITS-1:0] q, hs;
	assign q  = oldest_q;
	assign hs = t_rd[SLOT_BITS-1:0];

	// tile counts across and down
	logic [7:0] tx, ty;
	assign tx = {1'b0, 7'((width_q - 16'd1) >> TILE_BITS)} + 8'd1;
	assign ty = {1'b0, 7'((height_q - 16'd1) >> TILE_BITS)} + 8'd1;

	logic [15:0] in_col, in_row;
	logic [4:0]  in_band;
	logic        in_bad;
	assign in_band = s_tdata[4:0];
	assign in_col  = s_tdata[20:5];
	assign in_row  = s_tdata[36:21];
	assign in_bad  = (in_col == 16'd0) || (in_col > width_q) || (in_row == 16'd0) ||
		(in_row > height_q) || (in_band == 5'd0) || (in_band > bands_q);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_q;

	logic out_free;
	assign out_free = !out_v_q || m_tready;

	// RAM port control
	always_comb begin
		t_we = 1'b0; t_wa = tile_q[TIDX_BITS-1:0]; t_wd = '0; t_ra = tile_q[TIDX_BITS-1:0];
		st_we = 1'b0; st_wa = q; st_wd = tile_q[TIDX_BITS-1:0]; st_ra = q;
		on_we = 1'b0; on_wa = q; on_wd = q; on_ra = q;
		op_we = 1'b0; op_wa = q; op_wd = q; op_ra = q;
		unique case (state_q)
			S_CLR: begin
				t_we = 1'b1;
				t_wa = clr_q;
			end
			S_CHK: begin
				on_ra = hs;
				op_ra = hs;
				if (!t_rd[MAP_W-1]) begin
					st_we = 1'b1;
					if (stile_v_q[q]) begin
						t_we = 1'b1;
						t_wa = st_rd;
					end
				end
			end
			S_MISS: begin
				// oldest has already moved on; the victim slot sits in s_q
				t_we = 1'b1;
				t_wd = {1'b1, s_q};
			end
			S_RD: begin
				// next[sp] = sn, prev[sn] = sp
				on_we = 1'b1; on_wa = op_val; on_wd = on_val;
				op_we = 1'b1; op_wa = on_val; op_wd = op_val;
			end
			S_RL2: begin
				on_we = 1'b1; on_wa = qp_q; on_wd = s_q;
				op_we = 1'b1; op_wa = s_q;  op_wd = qp_q;
			end
			S_RL3: begin
				on_we = 1'b1; on_wa = s_q; on_wd = q;
				op_we = 1'b1; op_wa = q;   op_wd = s_q;
			end
			default: ;
		endcase
	end

	// result assembly
	logic [15:0] fw_full, fh_full;
	logic [9:0]  fw, fh;
	logic [71:0] res;
	assign fw_full = width_q - {bx_q, 9'd0};
	assign fh_full = height_q - {by_q, 9'd0};
	assign fw = (fw_full < 16'(TILE_SIZE)) ? fw_full[9:0] : 10'(TILE_SIZE);
	assign fh = (fh_full < 16'(TILE_SIZE)) ? fh_full[9:0] : 10'(TILE_SIZE);

	always_comb begin
		res = '0;
		res[1:0] = status_q;
		if (status_q == ST_OK) begin
			res[2]     = hit_q;
			res[8:3]   = s_q;
			res[17:9]  = 9'(col_q - 16'd1);
			res[26:18] = 9'(row_q - 16'd1);
			if (!hit_q) begin
				res[27]    = ed_q;
				res[39:28] = et_q;
				res[51:40] = tile_q[TIDX_BITS-1:0];
				res[61:52] = fw;
				res[71:62] = fh;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			width_q   <= 16'd512;
			height_q  <= 16'd512;
			bands_q   <= 5'd1;
			oldest_q  <= '0;
			stile_v_q <= '0;
			dirty_q   <= '0;
			onext_w_q <= '0;
			oprev_w_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_BANDS:  bands_q  <= cfg_data[4:0];
					default: ;
				endcase
			end
			// in S_OUT the output register is handled by the sequencer below
			if (m_tready && state_q != S_OUT) begin
				out_v_q <= 1'b0;
			end
			if (on_we) onext_w_q[on_wa] <= 1'b1;
			if (op_we) oprev_w_q[op_wa] <= 1'b1;

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TIDX_BITS'(TILES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_TILE;
				S_TILE: state_q <= S_LOOK;
				S_LOOK: begin
					if (bad_q) begin
						status_q <= ST_BAD;
						state_q  <= S_OUT;
					end else if (tile_q >= 21'(TILES)) begin
						status_q <= ST_OVER;
						state_q  <= S_OUT;
					end else begin
						status_q <= ST_OK;
						state_q  <= S_CHK;
					end
				end
				S_CHK: begin
					prevq_q <= op_val;
					ed_q    <= 1'b0;
					et_q    <= '0;
					if (t_rd[MAP_W-1]) begin
						hit_q <= 1'b1;
						s_q   <= hs;
						if (hs == q) begin
							oldest_q <= on_val;
							state_q  <= S_OUT;
						end else if (hs == op_val) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						hit_q <= 1'b0;
						s_q   <= q;
						if (stile_v_q[q] && dirty_q[q]) begin
							ed_q <= 1'b1;
							et_q <= st_rd;
						end
						stile_v_q[q] <= 1'b1;
						oldest_q     <= on_val;
						state_q      <= S_MISS;
					end
				end
				S_MISS: state_q <= S_OUT;
				S_RD: begin
					// prev[q] already rewritten if sn is the oldest slot
					qp_q    <= (on_val == q) ? op_val : prevq_q;
					state_q <= S_RL2;
				end
				S_RL2: state_q <= S_RL3;
				S_RL3: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_q   <= res;
						out_v_q <= 1'b1;
						if (status_q == ST_OK) begin
							if (!hit_q) begin
								dirty_q[s_q] <= wr_q;
							end else if (wr_q) begin
								dirty_q[s_q] <= 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		on_ra_q <= on_ra;
		op_ra_q <= op_ra;
		if (s_tvalid && s_tready) begin
			wr_q   <= s_tuser;
			band_q <= in_band;
			col_q  <= in_col;
			row_q  <= in_row;
			bad_q  <= in_bad;
			bx_q   <= 7'((in_col - 16'd1) >> TILE_BITS);
			by_q   <= 7'((in_row - 16'd1) >> TILE_BITS);
		end
		if (state_q == S_MUL) begin
			txty_q <= 16'(tx) * 16'(ty);
			bytx_q <= 15'({1'b0, by_q} * tx);
		end
		if (state_q == S_TILE) begin
			tile_q <= 21'((band_q - 5'd1) * txty_q) + 21'(bytx_q) + 21'(bx_q);
		end
	end

	// no request taken while the table is being cleared
	a_clr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !s_tready)
		else $error("request accepted during clearing pass");

	// rejected requests carry nothing but the status
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[71:2] == '0))
		else $error("rejected result has nonzero fields");

	// a hit never asks for a fill or a write-back
	a_hit_nofill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[71:27] == '0))
		else $error("hit result carries fill or eviction");

	// a fresh result is loaded only into a free output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_v_q && !m_tready) |=> (state_q == S_OUT))
		else $error("result dropped under stall");

endmodule

// ===== rtl/rtc_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module rtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd <= mem[ra];
	end

endmodule

// ===== tb/raster_tile_cache_lru_core_tb.sv =====
// Self-checking testbench for the raster tile cache tag and LRU replacement core.
module raster_tile_cache_lru_core_tb
	import rtc_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// one tile-cache lookup outcome, fields as they sit in m_tdata
	typedef struct packed {
		logic [9:0]  fill_height;
		logic [9:0]  fill_width;
		logic [11:0] fill_tile;
		logic [11:0] evict_tile;
		logic        evict_dirty;
		logic [8:0]  offset_row;
		logic [8:0]  offset_col;
		logic [5:0]  slot;
		logic        hit;
		logic [1:0]  status;
	} lookup_t;

	typedef struct {
		logic        wr;
		logic [4:0]  band;
		logic [15:0] col;
		logic [15:0] row;
		logic        known;  // expected result typed into the row
		lookup_t     res;
	} req_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;

	raster_tile_cache_lru_core dut (.*);

	always #10 clk = ~clk;

	// shadow copy of the cache bookkeeping
	logic [15:0] img_w, img_h;
	logic [4:0]  n_bands;
	logic        map_vld [TILES];
	logic [5:0]  map_slot [TILES];
	logic        slot_vld [SLOTS];
	logic [11:0] slot_tag [SLOTS];
	logic        slot_drt [SLOTS];
	logic [5:0]  lru_next [SLOTS];
	logic [5:0]  lru_prev [SLOTS];
	logic [5:0]  lru_head;

	lookup_t pending_lookups [$];
	int      errors = 0;
	int      n_reqs = 0, n_hits = 0, n_miss = 0, n_evict = 0, n_rej = 0;
	int      send_idle = 0, recv_stall = 0;

	function automatic void cache_reset();
		img_w = 16'd512;
		img_h = 16'd512;
		n_bands = 5'd1;
		for (int i = 0; i < TILES; i++) begin
			map_vld[i] = 1'b0;
			map_slot[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			slot_vld[i] = 1'b0;
			slot_tag[i] = '0;
			slot_drt[i] = 1'b0;
			lru_next[i] = 6'(i + 1);
			lru_prev[i] = 6'(i - 1);
		end
		lru_head = '0;
	endfunction

	function automatic lookup_t cache_access(logic wr, logic [4:0] band,
			logic [15:0] col, logic [15:0] row);
		lookup_t r;
		longint tx, ty, bx, by, tidx;
		logic [5:0] s, q, sp, sn, qp;
		r = '0;
		if (col < 1 || col > img_w || row < 1 || row > img_h ||
				band < 1 || band > n_bands) begin
			r.status = ST_BAD;
			return r;
		end
		tx = (longint'(img_w) - 1) / TILE_SIZE + 1;
		ty = (longint'(img_h) - 1) / TILE_SIZE + 1;
		bx = (longint'(col) - 1) / TILE_SIZE;
		by = (longint'(row) - 1) / TILE_SIZE;
		tidx = (longint'(band) - 1) * tx * ty + by * tx + bx;
		if (tidx >= TILES) begin
			r.status = ST_OVER;
			return r;
		end
		r.status = ST_OK;
		q = lru_head;
		if (map_vld[tidx]) begin
			r.hit = 1'b1;
			s = map_slot[tidx];
			if (s == q) begin
				lru_head = lru_next[q];
			end else if (s != lru_prev[q]) begin
				// unlink s, then splice it in just ahead of the oldest
				sp = lru_prev[s];
				sn = lru_next[s];
				lru_next[sp] = sn;
				lru_prev[sn] = sp;
				qp = lru_prev[q];
				lru_next[qp] = s;
				lru_prev[s] = qp;
				lru_next[s] = q;
				lru_prev[q] = s;
			end
		end else begin
			s = q;
			if (slot_vld[s]) begin
				if (slot_drt[s]) begin
					r.evict_dirty = 1'b1;
					r.evict_tile = slot_tag[s];
				end
				map_vld[slot_tag[s]] = 1'b0;
			end
			map_vld[tidx] = 1'b1;
			map_slot[tidx] = s;
			slot_vld[s] = 1'b1;
			slot_tag[s] = 12'(tidx);
			slot_drt[s] = 1'b0;
			r.fill_tile = 12'(tidx);
			r.fill_width = 10'((longint'(img_w) - bx * TILE_SIZE) < TILE_SIZE ?
				(longint'(img_w) - bx * TILE_SIZE) : TILE_SIZE);
			r.fill_height = 10'((longint'(img_h) - by * TILE_SIZE) < TILE_SIZE ?
				(longint'(img_h) - by * TILE_SIZE) : TILE_SIZE);
			lru_head = lru_next[q];
		end
		if (wr)
			slot_drt[s] = 1'b1;
		r.slot = s;
		r.offset_col = 9'((col - 16'd1) % TILE_SIZE);
		r.offset_row = 9'((row - 16'd1) % TILE_SIZE);
		return r;
	endfunction

	// register write, only issued while the core is idle
	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH:  img_w = val;
			REG_HEIGHT: img_h = val;
			REG_BANDS:  n_bands = val[4:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one request transaction; expectation queued at acceptance
	task automatic send_req(logic wr, logic [4:0] band, logic [15:0] col,
			logic [15:0] row, logic known, lookup_t typed);
		lookup_t pred;
		@(posedge clk);
		while ($urandom_range(99) < send_idle)
			@(posedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= wr;
		s_tdata <= {3'b000, row, col, band};
		do @(posedge clk); while (!s_tready);
		pred = cache_access(wr, band, col, row);
		if (known && pred != typed) begin
			$error("typed row disagrees with predictor: exp %h pred %h", typed, pred);
			errors++;
		end
		pending_lookups = {pending_lookups, pred};
		n_reqs++;
		if (pred.status != ST_OK) n_rej++;
		else if (pred.hit) n_hits++;
		else n_miss++;
		if (pred.evict_dirty) n_evict++;
		s_tvalid <= 1'b0;
	endtask

	// receiver: random stall, compare each result field by field
	always @(posedge clk) begin
		lookup_t got, exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = lookup_t'(m_tdata);
				if (pending_lookups.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					exp_r = pending_lookups.pop_front();
					if (got.status != exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, got.status);
						errors++;
					end
					if (got.hit != exp_r.hit) begin
						$error("hit exp %0d got %0d", exp_r.hit, got.hit); errors++;
					end
					if (got.slot != exp_r.slot) begin
						$error("slot exp %0d got %0d", exp_r.slot, got.slot); errors++;
					end
					if (got.offset_col != exp_r.offset_col) begin
						$error("offset_col exp %0d got %0d", exp_r.offset_col,
							got.offset_col);
						errors++;
					end
					if (got.offset_row != exp_r.offset_row) begin
						$error("offset_row exp %0d got %0d", exp_r.offset_row,
							got.offset_row);
						errors++;
					end
					if (got.evict_dirty != exp_r.evict_dirty) begin
						$error("evict_dirty exp %0d got %0d", exp_r.evict_dirty,
							got.evict_dirty);
						errors++;
					end
					if (got.evict_tile != exp_r.evict_tile) begin
						$error("evict_tile exp %0d got %0d", exp_r.evict_tile,
							got.evict_tile);
						errors++;
					end
					if (got.fill_tile != exp_r.fill_tile) begin
						$error("fill_tile exp %0d got %0d", exp_r.fill_tile,
							got.fill_tile);
						errors++;
					end
					if (got.fill_width != exp_r.fill_width) begin
						$error("fill_width exp %0d got %0d", exp_r.fill_width,
							got.fill_width);
						errors++;
					end
					if (got.fill_height != exp_r.fill_height) begin
						$error("fill_height exp %0d got %0d", exp_r.fill_height,
							got.fill_height);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic lookup_t rej(status_t st);
		lookup_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	function automatic lookup_t miss_at(logic [5:0] s, logic [8:0] oc, logic [8:0] orow,
			logic [11:0] ft, logic [9:0] fw, logic [9:0] fh);
		lookup_t r;
		r = '0;
		r.slot = s;
		r.offset_col = oc;
		r.offset_row = orow;
		r.fill_tile = ft;
		r.fill_width = fw;
		r.fill_height = fh;
		return r;
	endfunction

	// directed rows at reset geometry (512x512, one band)
	req_row_t directed [] = '{
		'{1'b0, 5'd1, 16'd1, 16'd1, 1'b1, miss_at(6'd0, 9'd0, 9'd0, 12'd0, 10'd512, 10'd512)},
		'{1'b1, 5'd1, 16'd512, 16'd512, 1'b0, '0},
		'{1'b0, 5'd1, 16'd0, 16'd1, 1'b1, rej(ST_BAD)},
		'{1'b0, 5'd1, 16'd1, 16'd0, 1'b1, rej(ST_BAD)},
		'{1'b0, 5'd1, 16'd513, 16'd1, 1'b1, rej(ST_BAD)},
		'{1'b0, 5'd1, 16'd1, 16'd513, 1'b1, rej(ST_BAD)},
		'{1'b0, 5'd0, 16'd1, 16'd1, 1'b1, rej(ST_BAD)},
		'{1'b0, 5'd2, 16'd1, 16'd1, 1'b1, rej(ST_BAD)},
		'{1'b1, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1, rej(ST_BAD)}
	};

	// random request, mostly in range, some near edges, some junk
	task automatic rand_req(int hot);
		logic [4:0] b;
		logic [15:0] c, r;
		int k;
		k = $urandom_range(99);
		if (k < 8) begin
			b = 5'($urandom);
			c = 16'($urandom);
			r = 16'($urandom);
		end else begin
			b = 5'($urandom_range(1, n_bands));
			if (hot != 0 && k < 70) begin
				// small working set to provoke hits and relinks
				c = 16'(1 + ($urandom_range(0, hot) % ((img_w + 511) / 512)) * 512
					+ $urandom_range(0, 511));
				r = 16'($urandom_range(1, img_h));
				if (c > img_w) c = img_w;
			end else begin
				c = 16'($urandom_range(1, img_w));
				r = 16'($urandom_range(1, img_h));
			end
			if (k < 12) c = img_w + 16'($urandom_range(0, 1));
		end
		send_req(1'($urandom), b, c, r, 1'b0, '0);
	endtask

	initial begin
		cache_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: reset geometry, edges, rejects
		foreach (directed[i])
			send_req(directed[i].wr, directed[i].band, directed[i].col, directed[i].row,
				directed[i].known, directed[i].res);
		drain();

		// 16 bands of 8x8 tiles, last band still inside the table
		write_reg(REG_WIDTH, 16'd4096);
		write_reg(REG_HEIGHT, 16'd4096);
		write_reg(REG_BANDS, 16'd16);
		send_req(1'b0, 5'd16, 16'd4096, 16'd4096, 1'b0, '0);
		send_req(1'b1, 5'd1, 16'd4096, 16'd1, 1'b0, '0);
		// extremes of the width/height registers, far rows overflow the table
		drain();
		write_reg(REG_WIDTH, 16'hFFFF);
		write_reg(REG_HEIGHT, 16'hFFFF);
		write_reg(REG_BANDS, 16'd1);
		send_req(1'b0, 5'd1, 16'hFFFF, 16'hFFFF, 1'b0, '0);
		send_req(1'b0, 5'd1, 16'hFFFF, 16'd1, 1'b0, '0);
		send_req(1'b1, 5'd1, 16'd1, 16'hFFFF, 1'b0, '0);
		drain();
		write_reg(REG_WIDTH, 16'd1);
		write_reg(REG_HEIGHT, 16'd1);
		write_reg(REG_BANDS, 16'd0);
		send_req(1'b0, 5'd1, 16'd1, 16'd1, 1'b0, '0);
		drain();
		write_reg(REG_BANDS, 16'd1);
		send_req(1'b1, 5'd1, 16'd1, 16'd1, 1'b0, '0);
		send_req(1'b0, 5'd1, 16'd1, 16'd1, 1'b0, '0);
		drain();

		// random phases: idling mix and geometry change per phase
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 82; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 82; end
				default: begin send_idle = 35; recv_stall = 35; end
			endcase
			write_reg(REG_WIDTH, 16'($urandom_range(1, 3000)));
			write_reg(REG_HEIGHT, 16'($urandom_range(1, 3000)));
			write_reg(REG_BANDS, 16'($urandom_range(1, 16)));
			for (int i = 0; i < 100; i++) begin
				rand_req(ph < 4 ? 3 : 90);
				if (i == 50)
					while (pending_lookups.size() != 0) @(posedge clk);
			end
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		drain();
		$display("covered %0d requests: %0d hits, %0d misses, %0d dirty evictions, %0d rejects",
			n_reqs, n_hits, n_miss, n_evict, n_rej);
		$display("geometry changes across reset, extreme and random sizes, four idle mixes");
		if (errors == 0 && pending_lookups.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
